// ----- rtl/jts_pkg.sv -----
// Shared types, codes, constants and helper functions of the JSON token serializer.
package jts_pkg;

    localparam int STACK_DEPTH = 8;
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = 4;
    localparam int MAX_RESULTS = 50;
    localparam int CNT_W       = 6;
    localparam int IND_W       = 5;
    localparam int TXT_N       = 8;
    localparam int TXT_W       = $clog2(TXT_N);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int NUM_DIGITS  = 20;
    localparam int POW_W       = 5;

    // token commands
    localparam logic [3:0] CMD_OBJ_BEGIN = 4'd0;
    localparam logic [3:0] CMD_OBJ_END   = 4'd1;
    localparam logic [3:0] CMD_ARR_BEGIN = 4'd2;
    localparam logic [3:0] CMD_ARR_END   = 4'd3;
    localparam logic [3:0] CMD_NULL      = 4'd4;
    localparam logic [3:0] CMD_BOOL      = 4'd5;
    localparam logic [3:0] CMD_INT       = 4'd6;
    localparam logic [3:0] CMD_STR_START = 4'd7;
    localparam logic [3:0] CMD_STR_CHAR  = 4'd8;
    localparam logic [3:0] CMD_STR_END   = 4'd9;

    // nesting level codes
    localparam logic [2:0] LV_BEGIN     = 3'd0;
    localparam logic [2:0] LV_FINISH    = 3'd1;
    localparam logic [2:0] LV_OBJ_BEGIN = 3'd2;
    localparam logic [2:0] LV_OBJ_KEY   = 3'd3;
    localparam logic [2:0] LV_OBJ_VALUE = 3'd4;
    localparam logic [2:0] LV_ARR_BEGIN = 3'd5;
    localparam logic [2:0] LV_ARR_ELEM  = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FINISHED  = 3'd1;
    localparam logic [2:0] ST_BAD_KEY   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_UNMATCHED = 3'd4;
    localparam logic [2:0] ST_ORDER     = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRETTY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDENT_W    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INDENT_BYTE = 2'd2;

    typedef struct packed {
        logic       req;
        logic [7:0] data;
        logic       text;
        logic [2:0] status;
    } emit_t;

    typedef struct packed {
        logic       ready;
        logic [3:0] digit;
        logic       sig;
        logic       last;
    } dig_stat_t;

    typedef struct packed {
        logic [TXT_W:0]         len;
        logic [TXT_N-1:0][7:0] bytes;
    } text_t;

    function automatic logic [63:0] pow10(input logic [POW_W-1:0] k);
        logic [63:0] p;
        case (k)
            5'd0:    p = 64'd1;
            5'd1:    p = 64'd10;
            5'd2:    p = 64'd100;
            5'd3:    p = 64'd1000;
            5'd4:    p = 64'd10000;
            5'd5:    p = 64'd100000;
            5'd6:    p = 64'd1000000;
            5'd7:    p = 64'd10000000;
            5'd8:    p = 64'd100000000;
            5'd9:    p = 64'd1000000000;
            5'd10:   p = 64'd10000000000;
            5'd11:   p = 64'd100000000000;
            5'd12:   p = 64'd1000000000000;
            5'd13:   p = 64'd10000000000000;
            5'd14:   p = 64'd100000000000000;
            5'd15:   p = 64'd1000000000000000;
            5'd16:   p = 64'd10000000000000000;
            5'd17:   p = 64'd100000000000000000;
            5'd18:   p = 64'd1000000000000000000;
            5'd19:   p = 64'd10000000000000000000;
            default: p = 64'd0;
        endcase
        return p;
    endfunction

    // next level state once a value completes at this level
    function automatic logic [2:0] level_adv(input logic [2:0] s);
        logic [2:0] n;
        case (s)
            LV_BEGIN:                n = LV_FINISH;
            LV_OBJ_BEGIN, LV_OBJ_KEY: n = LV_OBJ_VALUE;
            LV_OBJ_VALUE:            n = LV_OBJ_KEY;
            LV_ARR_BEGIN:            n = LV_ARR_ELEM;
            default:                 n = s;
        endcase
        return n;
    endfunction

    function automatic text_t text1(input logic [7:0] b);
        text_t t;
        t       = '0;
        t.len   = 4'd1;
        t.bytes[0] = b;
        return t;
    endfunction

    function automatic text_t text2(input logic [7:0] b0, input logic [7:0] b1);
        text_t t;
        t          = '0;
        t.len      = 4'd2;
        t.bytes[0] = b0;
        t.bytes[1] = b1;
        return t;
    endfunction

    // escaped form of one string byte, first byte in slot zero
    function automatic text_t escape_char(input logic [7:0] c);
        text_t t;
        t = '0;
        case (c)
            8'h22:   t = text2(8'h5C, 8'h22);
            8'h5C:   t = text2(8'h5C, 8'h5C);
            8'h2F:   t = text2(8'h5C, 8'h2F);
            8'h08:   t = text2(8'h5C, 8'h62);
            8'h0C:   t = text2(8'h5C, 8'h66);
            8'h0A:   t = text2(8'h5C, 8'h6E);
            8'h0D:   t = text2(8'h5C, 8'h72);
            8'h09:   t = text2(8'h5C, 8'h74);
            default: begin
                if (c <= 8'h1F) begin
                    t.len      = 4'd6;
                    t.bytes[0] = 8'h5C;
                    t.bytes[1] = 8'h75;
                    t.bytes[2] = 8'h30;
                    t.bytes[3] = 8'h30;
                    t.bytes[4] = 8'h30 | {7'd0, c[4]};
                    t.bytes[5] = (c[3:0] < 4'd10) ? (8'h30 + {4'd0, c[3:0]})
                                                  : (8'h37 + {4'd0, c[3:0]});
                end else begin
                    t = text1(c);
                end
            end
        endcase
        return t;
    endfunction

endpackage

// ----- rtl/jts_digit_unit.sv -----
// Compare-subtract unit that peels decimal digits off a 64-bit magnitude.
module jts_digit_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  logic signed [63:0]  value,
    input  logic                run,
    input  logic                adv,
    output jts_pkg::dig_stat_t  stat
);
    import jts_pkg::*;

    logic [63:0]      mag_reg;
    logic [POW_W-1:0] k_reg;
    logic [3:0]       dig_reg;
    logic             started_reg;
    logic [63:0]      pw;
    logic             ge;

    assign pw = pow10(k_reg);
    assign ge = (mag_reg >= pw);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= '0;
            dig_reg     <= '0;
            started_reg <= 1'b0;
        end else if (load) begin
            k_reg       <= POW_W'(NUM_DIGITS - 1);
            dig_reg     <= '0;
            started_reg <= 1'b0;
        end else if (run) begin
            if (adv) begin
                started_reg <= started_reg | (dig_reg != 4'd0);
                k_reg       <= k_reg - 1'b1;
                dig_reg     <= '0;
            end else if (ge) begin
                dig_reg <= dig_reg + 1'b1;
            end
        end
    end

    // magnitude register: load the absolute value, subtract while at or above the power
    always_ff @(posedge aclk) begin
        if (load) begin
            mag_reg <= value[63] ? (64'd0 - value) : value;
        end else if (run && !adv && ge) begin
            mag_reg <= mag_reg - pw;
        end
    end

    assign stat.ready = !ge;
    assign stat.digit = dig_reg;
    assign stat.sig   = (dig_reg != 4'd0) || started_reg || (k_reg == '0);
    assign stat.last  = (k_reg == '0);

endmodule

// ----- rtl/jts_out_stage.sv -----
// One-byte hold stage plus output register; marks the final byte of a run.
module jts_out_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  jts_pkg::emit_t  emit,
    input  logic            fin,
    output logic            ok,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_byte_valid,
    output logic [2:0]      m_status,
    output logic            m_last_of_run
);
    import jts_pkg::*;

    logic       pend_v_reg;
    logic [7:0] pend_data_reg;
    logic       pend_text_reg;
    logic [2:0] pend_status_reg;
    logic       m_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_text_reg;
    logic [2:0] out_status_reg;
    logic       out_last_reg;
    logic       out_free;
    logic       push;

    assign out_free = !m_valid_reg || m_ready;
    assign ok       = !pend_v_reg || out_free;
    assign push     = (emit.req || fin) && ok && pend_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (emit.req && ok) begin
                pend_v_reg <= 1'b1;
            end else if (fin && ok) begin
                pend_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            out_data_reg   <= pend_data_reg;
            out_text_reg   <= pend_text_reg;
            out_status_reg <= pend_status_reg;
            out_last_reg   <= fin;
        end
        if (emit.req && ok) begin
            pend_data_reg   <= emit.data;
            pend_text_reg   <= emit.text;
            pend_status_reg <= emit.status;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = out_data_reg;
    assign m_byte_valid  = out_text_reg;
    assign m_status      = out_status_reg;
    assign m_last_of_run = out_last_reg;

endmodule

// ----- rtl/json_token_serializer.sv -----
// Top level of the JSON token serializer: sequencer, nesting stack and configuration.
//
//  channel | direction | handshake           | payload
//  s_      | in        | s_valid / s_ready   | command, flag_value, char_byte, integer_value
//  m_      | out       | m_valid / m_ready   | out_byte, byte_valid, status, last_of_run
//  cfg_    | in        | cfg_wr_en           | cfg_index, cfg_wdata
//
// One command passes through the idle state of its transfer, a decode state (and a close
// state for a close), the separator, indent and text byte phases at one byte per cycle while
// the output takes them, and a final flush state.
// An integer then runs the compare-subtract unit over the twenty decimal positions,
// subtracting powers of ten from the magnitude to find each digit.
// Reset is synchronous and active low; it clears the stack root, depth and registers.
// A stalled m_ready holds the sequencer at its next byte; s_ready is high only when idle.
module json_token_serializer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [3:0]                    s_command,
    input  logic                          s_flag_value,
    input  logic [7:0]                    s_char_byte,
    input  logic signed [63:0]            s_integer_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_byte,
    output logic                          m_byte_valid,
    output logic [2:0]                    m_status,
    output logic                          m_last_of_run,
    input  logic                          cfg_wr_en,
    input  logic [jts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jts_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import jts_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_CLOSE  = 3'd2;
    localparam logic [2:0] S_PRE    = 3'd3;
    localparam logic [2:0] S_IND    = 3'd4;
    localparam logic [2:0] S_TXT    = 3'd5;
    localparam logic [2:0] S_DEC    = 3'd6;
    localparam logic [2:0] S_FIN    = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [3:0]         cmd_reg;
    logic               flag_reg;
    logic [7:0]         char_reg;
    logic signed [63:0] int_reg;
    logic               pretty_reg;
    logic [2:0]         iw_reg;
    logic [7:0]         ib_reg;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               so_reg, so_next;
    logic [2:0]         lvl_mem [STACK_DEPTH];
    logic [1:0][7:0]    pre_reg, pre_next;
    logic [1:0]         pre_len_reg, pre_len_next;
    logic [1:0]         pre_idx_reg, pre_idx_next;
    logic [IND_W-1:0]   ind_reg, ind_next;
    text_t              txt_reg, txt_next;
    logic [TXT_W:0]     txt_idx_reg, txt_idx_next;
    logic               is_int_reg, is_int_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic               lv_we;
    logic [IDX_W-1:0]   lv_wa;
    logic [2:0]         lv_wd;
    logic [IDX_W-1:0]   didx;
    logic [2:0]         lv_cur;
    logic [2:0]         w_sat;
    logic [IND_W-1:0]   ind_calc;
    logic               want;
    logic [7:0]         want_byte;
    logic               cap;
    logic               take;
    logic               out_ok;
    logic               fin;
    logic               dig_load;
    logic               dig_adv;
    emit_t              emit;
    dig_stat_t          dstat;
    logic [2:0]         rej;
    logic               reject;

    assign didx     = depth_reg[IDX_W-1:0];
    assign lv_cur   = lvl_mem[didx];
    assign w_sat    = (iw_reg > 3'd4) ? 3'd4 : iw_reg;
    assign ind_calc = IND_W'({2'b00, didx} * {2'b00, w_sat});
    assign cap      = (cnt_reg == CNT_W'(MAX_RESULTS));
    assign take     = out_ok || cap;
    assign s_ready  = (state_reg == S_IDLE);

    // drop bytes past the result limit, but keep walking the sequence
    assign emit.req    = (want && !cap) || reject;
    assign emit.data   = reject ? 8'h00 : want_byte;
    assign emit.text   = !reject;
    assign emit.status = reject ? rej : ST_OK;

    always_comb begin
        state_next   = state_reg;
        depth_next   = depth_reg;
        so_next      = so_reg;
        pre_next     = pre_reg;
        pre_len_next = pre_len_reg;
        pre_idx_next = pre_idx_reg;
        ind_next     = ind_reg;
        txt_next     = txt_reg;
        txt_idx_next = txt_idx_reg;
        is_int_next  = is_int_reg;
        cnt_next     = cnt_reg;
        lv_we        = 1'b0;
        lv_wa        = didx;
        lv_wd        = LV_BEGIN;
        want         = 1'b0;
        want_byte    = 8'h00;
        fin          = 1'b0;
        dig_load     = 1'b0;
        dig_adv      = 1'b0;
        rej          = ST_OK;
        reject       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                pre_idx_next = '0;
                pre_len_next = '0;
                txt_idx_next = '0;
                ind_next     = '0;
                is_int_next  = 1'b0;
                cnt_next     = '0;
                // separator ahead of a value or key
                if (lv_cur inside {LV_OBJ_KEY, LV_ARR_ELEM}) begin
                    pre_next     = {8'h0A, 8'h2C};
                    pre_len_next = pretty_reg ? 2'd2 : 2'd1;
                end else if (lv_cur == LV_OBJ_VALUE) begin
                    pre_next     = {8'h20, 8'h3A};
                    pre_len_next = pretty_reg ? 2'd2 : 2'd1;
                end
                if (pretty_reg && lv_cur != LV_OBJ_VALUE) begin
                    ind_next = ind_calc;
                end
                state_next = S_PRE;

                if (cmd_reg > CMD_STR_END) begin
                    state_next = S_IDLE;
                end else if (so_reg ? !(cmd_reg inside {CMD_STR_CHAR, CMD_STR_END})
                                    : (cmd_reg inside {CMD_STR_CHAR, CMD_STR_END})) begin
                    rej = ST_ORDER;
                end else if (cmd_reg == CMD_STR_CHAR) begin
                    pre_len_next = '0;
                    ind_next     = '0;
                    txt_next     = escape_char(char_reg);
                end else if (cmd_reg == CMD_STR_END) begin
                    pre_len_next = '0;
                    ind_next     = '0;
                    txt_next     = text1(8'h22);
                    lv_we        = 1'b1;
                    lv_wd        = level_adv(lv_cur);
                    so_next      = 1'b0;
                end else if (lv_cur == LV_FINISH) begin
                    rej = ST_FINISHED;
                end else if (cmd_reg inside {CMD_OBJ_END, CMD_ARR_END}) begin
                    if (depth_reg == '0) begin
                        rej = ST_UNMATCHED;
                    end else begin
                        depth_next   = depth_reg - 1'b1;
                        pre_next     = {8'h00, 8'h0A};
                        pre_len_next = pretty_reg ? 2'd1 : 2'd0;
                        txt_next     = text1((cmd_reg == CMD_OBJ_END) ? 8'h7D : 8'h5D);
                        state_next   = S_CLOSE;
                    end
                end else if (cmd_reg == CMD_STR_START) begin
                    txt_next = text1(8'h22);
                    so_next  = 1'b1;
                end else if (lv_cur inside {LV_OBJ_BEGIN, LV_OBJ_KEY}) begin
                    rej = ST_BAD_KEY;
                end else if (cmd_reg inside {CMD_OBJ_BEGIN, CMD_ARR_BEGIN}) begin
                    if (depth_reg == DEPTH_W'(STACK_DEPTH - 1)) begin
                        rej = ST_OVERFLOW;
                    end else begin
                        depth_next = depth_reg + 1'b1;
                        lv_we      = 1'b1;
                        lv_wa      = didx + 1'b1;
                        lv_wd      = (cmd_reg == CMD_OBJ_BEGIN) ? LV_OBJ_BEGIN : LV_ARR_BEGIN;
                        txt_next   = text2((cmd_reg == CMD_OBJ_BEGIN) ? 8'h7B : 8'h5B, 8'h0A);
                        if (!pretty_reg) begin
                            txt_next.len = 4'd1;
                        end
                    end
                end else begin
                    lv_we = 1'b1;
                    lv_wd = level_adv(lv_cur);
                    if (cmd_reg == CMD_NULL) begin
                        txt_next = '0;
                        txt_next.len = 4'd4;
                        txt_next.bytes[3:0] = {8'h6C, 8'h6C, 8'h75, 8'h6E};
                    end else if (cmd_reg == CMD_BOOL) begin
                        txt_next = '0;
                        if (flag_reg) begin
                            txt_next.len = 4'd4;
                            txt_next.bytes[3:0] = {8'h65, 8'h75, 8'h72, 8'h74};
                        end else begin
                            txt_next.len = 4'd5;
                            txt_next.bytes[4:0] = {8'h65, 8'h73, 8'h6C, 8'h61, 8'h66};
                        end
                    end else begin
                        txt_next     = text1(8'h2D);
                        txt_next.len = int_reg[63] ? 4'd1 : 4'd0;
                        is_int_next  = 1'b1;
                        dig_load     = 1'b1;
                    end
                end

                // rejection: single non-text result, nothing else changes
                if (rej != ST_OK) begin
                    reject     = 1'b1;
                    lv_we      = 1'b0;
                    depth_next = depth_reg;
                    so_next    = so_reg;
                    dig_load   = 1'b0;
                    state_next = out_ok ? S_FIN : S_DECODE;
                end
            end
            S_CLOSE: begin
                // parent level, read after the depth drop
                lv_we    = 1'b1;
                lv_wd    = level_adv(lv_cur);
                ind_next = (pretty_reg && level_adv(lv_cur) != LV_OBJ_VALUE) ? ind_calc : '0;
                state_next = S_PRE;
            end
            S_PRE: begin
                if (pre_idx_reg == pre_len_reg) begin
                    state_next = S_IND;
                end else begin
                    want      = 1'b1;
                    want_byte = pre_reg[pre_idx_reg[0]];
                    if (take) begin
                        pre_idx_next = pre_idx_reg + 1'b1;
                    end
                end
            end
            S_IND: begin
                if (ind_reg == '0) begin
                    state_next = S_TXT;
                end else begin
                    want      = 1'b1;
                    want_byte = ib_reg;
                    if (take) begin
                        ind_next = ind_reg - 1'b1;
                    end
                end
            end
            S_TXT: begin
                if (txt_idx_reg == txt_reg.len) begin
                    state_next = is_int_reg ? S_DEC : S_FIN;
                end else begin
                    want      = 1'b1;
                    want_byte = txt_reg.bytes[txt_idx_reg[TXT_W-1:0]];
                    if (take) begin
                        txt_idx_next = txt_idx_reg + 1'b1;
                    end
                end
            end
            S_DEC: begin
                if (dstat.ready) begin
                    if (dstat.sig) begin
                        want      = 1'b1;
                        want_byte = 8'h30 | {4'h0, dstat.digit};
                        dig_adv   = take;
                    end else begin
                        dig_adv = 1'b1;
                    end
                    if (dig_adv && dstat.last) begin
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN: begin
                fin = 1'b1;
                if (out_ok) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (want && !cap && out_ok) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            depth_reg  <= '0;
            so_reg     <= 1'b0;
            pretty_reg <= 1'b0;
            iw_reg     <= 3'd2;
            ib_reg     <= 8'd32;
        end else begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            so_reg    <= so_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PRETTY:      pretty_reg <= cfg_wdata[0];
                    REG_INDENT_W:    iw_reg     <= cfg_wdata[2:0];
                    REG_INDENT_BYTE: ib_reg     <= cfg_wdata;
                    default:         ;
                endcase
            end
        end
    end

    // nesting stack: only the root entry has a reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl_mem[0] <= LV_BEGIN;
        end else if (lv_we) begin
            lvl_mem[lv_wa] <= lv_wd;
        end
    end

    // hold the accepted command and the per-command sequence counters
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg  <= s_command;
            flag_reg <= s_flag_value;
            char_reg <= s_char_byte;
            int_reg  <= s_integer_value;
        end
        pre_reg     <= pre_next;
        pre_len_reg <= pre_len_next;
        pre_idx_reg <= pre_idx_next;
        ind_reg     <= ind_next;
        txt_reg     <= txt_next;
        txt_idx_reg <= txt_idx_next;
        is_int_reg  <= is_int_next;
        cnt_reg     <= cnt_next;
    end

    jts_digit_unit u_digit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (dig_load),
        .value   (int_reg),
        .run     (state_reg == S_DEC),
        .adv     (dig_adv),
        .stat    (dstat)
    );

    jts_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .emit          (emit),
        .fin           (fin),
        .ok            (out_ok),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_status      (m_status),
        .m_last_of_run (m_last_of_run)
    );

`ifndef SYNTHESIS
    a_depth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(STACK_DEPTH - 1))
        else $error("nesting depth out of range");

    a_reject_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_last_of_run && m_status != ST_OK)
        else $error("status result not final or without code");

    a_text_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid |-> m_status == ST_OK)
        else $error("text byte with nonzero status");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after a transfer");
`endif

endmodule

// ----- test/tb_json_token_serializer.sv -----
// Self-checking testbench for the JSON token serializer.
`timescale 1ns / 1ps

module tb_json_token_serializer;
    import jts_pkg::*;

    // One text byte or one status result, as it leaves the m_ channel.
    typedef struct {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] status;
        logic       last_of_run;
    } text_beat_t;

    // One directed row; a typed row carries its own reject status.
    typedef struct {
        logic [3:0]         command;
        logic               flag_value;
        logic [7:0]         char_byte;
        logic signed [63:0] integer_value;
        bit                 typed;
        logic [2:0]         want_status;
    } token_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [3:0]             s_command = '0;
    logic                   s_flag_value = 1'b0;
    logic [7:0]             s_char_byte = '0;
    logic signed [63:0]     s_integer_value = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [7:0]             m_out_byte;
    logic                   m_byte_valid;
    logic [2:0]             m_status;
    logic                   m_last_of_run;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    json_token_serializer u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_flag_value    (s_flag_value),
        .s_char_byte     (s_char_byte),
        .s_integer_value (s_integer_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_byte_valid    (m_byte_valid),
        .m_status        (m_status),
        .m_last_of_run   (m_last_of_run),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shadow copy of the serializer state and its registers.
    logic [2:0]   nest_lv [STACK_DEPTH];
    logic [3:0]   nest_depth;
    logic         in_string;
    logic         pretty_on;
    logic [2:0]   indent_cnt;
    logic [7:0]   indent_chr;

    text_beat_t   text_q [$];     // bytes still owed by the block, oldest first
    int           err_cnt = 0;
    int           src_idle_pct = 0;
    int           snk_idle_pct = 0;
    int           stall_kick = 0; // bump to ask the receiver for a long hold-off

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %0s: got %0d expected %0d", what, got, want);
        err_cnt++;
    endtask

    // ---------------------------------------------------------------------
    // Text predictor
    // ---------------------------------------------------------------------
    function automatic logic [2:0] level_now();
        return nest_lv[nest_depth[IDX_W-1:0]];
    endfunction

    task automatic put_byte(input logic [7:0] b);
        text_beat_t t;
        t.out_byte = b;
        t.byte_valid = 1'b1;
        t.status = ST_OK;
        t.last_of_run = 1'b0;
        text_q.push_back(t);
    endtask

    task automatic put_reject(input logic [2:0] code);
        text_beat_t t;
        t.out_byte = 8'h00;
        t.byte_valid = 1'b0;
        t.status = code;
        t.last_of_run = 1'b1;
        text_q.push_back(t);
    endtask

    task automatic put_word(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    // Step the level once a value completes at the current depth.
    task automatic close_value();
        case (level_now())
            LV_BEGIN:                 nest_lv[nest_depth[IDX_W-1:0]] = LV_FINISH;
            LV_OBJ_BEGIN, LV_OBJ_KEY: nest_lv[nest_depth[IDX_W-1:0]] = LV_OBJ_VALUE;
            LV_OBJ_VALUE:             nest_lv[nest_depth[IDX_W-1:0]] = LV_OBJ_KEY;
            LV_ARR_BEGIN:             nest_lv[nest_depth[IDX_W-1:0]] = LV_ARR_ELEM;
            default: ;
        endcase
    endtask

    task automatic put_separator();
        if (level_now() == LV_OBJ_KEY || level_now() == LV_ARR_ELEM) begin
            put_byte(",");
            if (pretty_on) put_byte(8'h0A);
        end else if (level_now() == LV_OBJ_VALUE) begin
            put_byte(":");
            if (pretty_on) put_byte(" ");
        end
    endtask

    task automatic put_indent();
        int w;
        w = (indent_cnt > 3'd4) ? 4 : int'(indent_cnt);
        if (!pretty_on || level_now() == LV_OBJ_VALUE) return;
        for (int d = 0; d < nest_depth; d++)
            for (int k = 0; k < w; k++) put_byte(indent_chr);
    endtask

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        return (v < 4'd10) ? (8'h30 + v) : (8'h41 + v - 4'd10);
    endfunction

    task automatic put_decimal(input logic [63:0] raw);
        logic [63:0] mag;
        logic [7:0]  digs [20];
        int          n;
        n = 0;
        mag = raw[63] ? (64'd0 - raw) : raw;
        do begin
            digs[n] = 8'h30 + 8'(mag % 64'd10);
            n++;
            mag = mag / 64'd10;
        end while (mag != 0 && n < 20);
        if (raw[63]) put_byte("-");
        while (n > 0) begin
            n--;
            put_byte(digs[n]);
        end
    endtask

    task automatic put_escaped(input logic [7:0] c);
        case (c)
            8'h22: put_word("\\\"");
            8'h5C: put_word("\\\\");
            8'h2F: put_word("\\/");
            8'h08: put_word("\\b");
            8'h0C: put_word("\\f");
            8'h0A: put_word("\\n");
            8'h0D: put_word("\\r");
            8'h09: put_word("\\t");
            default: begin
                if (c <= 8'h1F) begin
                    put_word("\\u00");
                    put_byte(hex_digit({3'd0, c[4]}));
                    put_byte(hex_digit(c[3:0]));
                end else begin
                    put_byte(c);
                end
            end
        endcase
    endtask

    // Work out the text for one accepted token and queue it.
    task automatic predict_text(input logic [3:0] cmd, input logic flag,
                                input logic [7:0] chr, input logic [63:0] ival);
        int first;
        logic [2:0] lv;
        first = text_q.size();
        if (cmd > CMD_STR_END) return;
        if (in_string ? (cmd != CMD_STR_CHAR && cmd != CMD_STR_END)
                      : (cmd == CMD_STR_CHAR || cmd == CMD_STR_END)) begin
            put_reject(ST_ORDER);
            return;
        end
        lv = level_now();
        if (cmd == CMD_STR_CHAR) begin
            put_escaped(chr);
        end else if (cmd == CMD_STR_END) begin
            put_byte(8'h22);
            close_value();
            in_string = 1'b0;
        end else if (lv == LV_FINISH) begin
            put_reject(ST_FINISHED);
            return;
        end else if (cmd == CMD_OBJ_END || cmd == CMD_ARR_END) begin
            if (nest_depth == 0) begin
                put_reject(ST_UNMATCHED);
                return;
            end
            nest_depth--;
            if (pretty_on) put_byte(8'h0A);
            close_value();
            put_indent();
            put_byte(cmd == CMD_OBJ_END ? "}" : "]");
        end else if (cmd == CMD_STR_START) begin
            put_separator();
            put_indent();
            put_byte(8'h22);
            in_string = 1'b1;
        end else begin
            if (lv == LV_OBJ_BEGIN || lv == LV_OBJ_KEY) begin
                put_reject(ST_BAD_KEY);
                return;
            end
            if ((cmd == CMD_OBJ_BEGIN || cmd == CMD_ARR_BEGIN) &&
                int'(nest_depth) + 1 >= STACK_DEPTH) begin
                put_reject(ST_OVERFLOW);
                return;
            end
            put_separator();
            put_indent();
            if (cmd == CMD_OBJ_BEGIN || cmd == CMD_ARR_BEGIN) begin
                nest_depth++;
                nest_lv[nest_depth[IDX_W-1:0]] =
                    (cmd == CMD_OBJ_BEGIN) ? LV_OBJ_BEGIN : LV_ARR_BEGIN;
                put_byte(cmd == CMD_OBJ_BEGIN ? "{" : "[");
                if (pretty_on) put_byte(8'h0A);
            end else begin
                if (cmd == CMD_NULL) put_word("null");
                else if (cmd == CMD_BOOL) begin
                    if (flag) put_word("true");
                    else put_word("false");
                end
                else put_decimal(ival);
                close_value();
            end
        end
        // keep at most the block's result count per token
        while (text_q.size() > first + MAX_RESULTS) void'(text_q.pop_back());
        if (text_q.size() > first) text_q[$].last_of_run = 1'b1;
    endtask

    // ---------------------------------------------------------------------
    // Sender: offer one token, hold it until the transfer, then predict
    // ---------------------------------------------------------------------
    task automatic send_token(input logic [3:0] cmd, input logic flag, input logic [7:0] chr,
                              input logic [63:0] ival, input bit typed = 0,
                              input logic [2:0] want = ST_OK);
        int first;
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= cmd;
        s_flag_value    <= flag;
        s_char_byte     <= chr;
        s_integer_value <= ival;
        do @(posedge aclk); while (!s_ready);
        first = text_q.size();
        predict_text(cmd, flag, chr, ival);
        if (typed) begin
            // the row's own status replaces the prediction
            if (text_q.size() != first + 1 || text_q[$].status != want)
                report("directed row status", text_q[$].status, want);
            while (text_q.size() > first) void'(text_q.pop_back());
            put_reject(want);
        end
    endtask

    // Drop valid, let every owed byte drain, then allow for trailing work.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (text_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic write_regs(input logic pretty, input logic [2:0] width,
                              input logic [7:0] chr);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_PRETTY;
        cfg_wdata <= {7'd0, pretty};
        @(posedge aclk);
        pretty_on = pretty;
        cfg_index <= REG_INDENT_W;
        cfg_wdata <= {5'd0, width};
        @(posedge aclk);
        indent_cnt = width;
        cfg_index <= REG_INDENT_BYTE;
        cfg_wdata <= chr;
        @(posedge aclk);
        indent_chr = chr;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Random integer with a spread of magnitudes and both signs.
    function automatic logic [63:0] rand_int();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = 64'h8000_0000_0000_0000;
            1: v = 64'h7FFF_FFFF_FFFF_FFFF;
            default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        return v;
    endfunction

    function automatic logic [7:0] rand_char();
        logic [7:0] pick [8] = '{8'h22, 8'h5C, 8'h2F, 8'h08, 8'h0C, 8'h0D, 8'h09, 8'h1F};
        return ($urandom_range(0, 3) == 0) ? pick[$urandom_range(0, 7)]
                                           : 8'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed tokens for the current state, plus some noise.
    task automatic send_random();
        logic [3:0] cmd;
        logic [2:0] lv;
        int r;
        r = $urandom_range(0, 99);
        lv = level_now();
        if (in_string) begin
            cmd = (r < 82) ? CMD_STR_CHAR : (r < 95) ? CMD_STR_END
                                                     : 4'($urandom_range(0, 7));
        end else if (r < 6) begin
            cmd = 4'($urandom_range(8, 15));   // out-of-order string bytes, unknowns
        end else if (lv == LV_OBJ_BEGIN || lv == LV_OBJ_KEY) begin
            cmd = (r < 85) ? CMD_STR_START : 4'($urandom_range(0, 6));
        end else if (r < 26) begin
            cmd = $urandom_range(0, 1) ? CMD_OBJ_BEGIN : CMD_ARR_BEGIN;
        end else if (r < 40) begin
            cmd = (nest_depth > 1) ? ($urandom_range(0, 1) ? CMD_OBJ_END : CMD_ARR_END)
                                   : CMD_NULL;
        end else if (r < 48) begin
            cmd = CMD_NULL;
        end else if (r < 58) begin
            cmd = CMD_BOOL;
        end else if (r < 75) begin
            cmd = CMD_INT;
        end else begin
            cmd = CMD_STR_START;
        end
        // never close the root array before the end of the run
        if ((cmd == CMD_OBJ_END || cmd == CMD_ARR_END) && nest_depth <= 1 && !in_string)
            cmd = CMD_NULL;
        send_token(cmd, 1'($urandom_range(0, 1)), rand_char(), rand_int());
    endtask

    // ---------------------------------------------------------------------
    // Receiver: random ready, with a long hold-off on request
    // ---------------------------------------------------------------------
    int stall_left = 0;
    int stall_seen = 0;
    always @(posedge aclk) begin
        if (stall_kick != stall_seen) begin
            stall_seen = stall_kick;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Compare every transfer on m_ with the oldest owed byte.
    always @(posedge aclk) begin
        text_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (text_q.size() == 0) begin
                report("unexpected result, byte", m_out_byte, 0);
            end else begin
                want = text_q.pop_front();
                if (m_out_byte !== want.out_byte) report("out_byte", m_out_byte, want.out_byte);
                if (m_byte_valid !== want.byte_valid)
                    report("byte_valid", m_byte_valid, want.byte_valid);
                if (m_status !== want.status) report("status", m_status, want.status);
                if (m_last_of_run !== want.last_of_run)
                    report("last_of_run", m_last_of_run, want.last_of_run);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Directed rows: opens the root array and keeps it open
    // ---------------------------------------------------------------------
    localparam logic signed [63:0] I_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] I_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    token_row_t dir_rows [] = '{
        '{CMD_STR_CHAR,  1'b0, 8'h41, 64'sd0, 1, ST_ORDER},     // char with no string open
        '{CMD_ARR_END,   1'b0, 8'h00, 64'sd0, 1, ST_UNMATCHED}, // close at depth zero
        '{CMD_ARR_BEGIN, 1'b0, 8'h00, 64'sd0, 0, ST_OK},
        '{CMD_OBJ_BEGIN, 1'b1, 8'hFF, -64'sd1, 0, ST_OK},
        '{CMD_INT,       1'b0, 8'h00, 64'sd5, 1, ST_BAD_KEY},   // value where a key is due
        '{CMD_STR_START, 1'b0, 8'h00, 64'sd0, 0, ST_OK},
        '{CMD_STR_CHAR,  1'b0, 8'h22, 64'sd0, 0, ST_OK},
        '{CMD_STR_CHAR,  1'b0, 8'h5C, 64'sd0, 0, ST_OK},
        '{CMD_STR_CHAR,  1'b0, 8'h2F, 64'sd0, 0, ST_OK},
        '{CMD_STR_CHAR,  1'b0, 8'h0A, 64'sd0, 0, ST_OK},
        '{CMD_STR_CHAR,  1'b0, 8'h00, 64'sd0, 0, ST_OK},
        '{CMD_STR_CHAR,  1'b0, 8'h1F, 64'sd0, 0, ST_OK},
        '{CMD_STR_CHAR,  1'b0, 8'hFF, 64'sd0, 0, ST_OK},
        '{CMD_STR_END,   1'b0, 8'h00, 64'sd0, 0, ST_OK},
        '{CMD_INT,       1'b0, 8'h00, I_MIN,  0, ST_OK},
        '{CMD_STR_START, 1'b0, 8'h00, 64'sd0, 0, ST_OK},
        '{CMD_OBJ_BEGIN, 1'b0, 8'h00, 64'sd0, 1, ST_ORDER},     // token inside a string
        '{CMD_STR_END,   1'b0, 8'h00, 64'sd0, 0, ST_OK},
        '{CMD_BOOL,      1'b1, 8'h00, 64'sd0, 0, ST_OK},
        '{CMD_ARR_BEGIN, 1'b0, 8'h00, 64'sd0, 1, ST_BAD_KEY},
        '{CMD_STR_START, 1'b0, 8'h00, 64'sd0, 0, ST_OK},
        '{CMD_STR_END,   1'b0, 8'h00, 64'sd0, 0, ST_OK},
        '{CMD_ARR_BEGIN, 1'b0, 8'h00, 64'sd0, 0, ST_OK},
        '{CMD_INT,       1'b0, 8'h00, I_MAX,  0, ST_OK},
        '{CMD_BOOL,      1'b0, 8'h00, 64'sd0, 0, ST_OK},
        '{CMD_OBJ_END,   1'b0, 8'h00, 64'sd0, 0, ST_OK},        // object end closes an array
        '{CMD_ARR_END,   1'b0, 8'h00, 64'sd0, 0, ST_OK},        // array end closes an object
        '{4'd15,         1'b1, 8'hFF, -64'sd1, 0, ST_OK}        // unknown command, no text
    };

    initial begin
        for (int i = 0; i < STACK_DEPTH; i++) nest_lv[i] = LV_BEGIN;
        nest_depth = '0;
        in_string = 1'b0;
        pretty_on = 1'b0;
        indent_cnt = 3'd2;
        indent_chr = 8'd32;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, sender idles 36 percent, receiver 73 percent
        src_idle_pct = 36;
        snk_idle_pct = 73;
        foreach (dir_rows[i])
            send_token(dir_rows[i].command, dir_rows[i].flag_value, dir_rows[i].char_byte,
                       dir_rows[i].integer_value, dir_rows[i].typed, dir_rows[i].want_status);

        // nest to the limit with wide indent; width 7 saturates to four bytes
        write_regs(1'b1, 3'd7, 8'h2E);
        while (nest_depth < STACK_DEPTH - 1) send_token(CMD_ARR_BEGIN, 0, 0, 0);
        send_token(CMD_INT, 0, 0, rand_int());
        send_token(CMD_OBJ_BEGIN, 0, 0, 0, 1, ST_OVERFLOW);
        send_token(CMD_ARR_BEGIN, 0, 0, 0, 1, ST_OVERFLOW);
        while (nest_depth > 1) send_token(CMD_OBJ_END, 0, 0, 0);

        // random phase one, with a long receiver hold-off in the middle
        write_regs(1'b1, 3'd0, 8'h00);
        for (int i = 0; i < 28; i++) begin
            if (i == 10) stall_kick++;
            send_random();
        end

        // random phase two: roles swapped
        write_regs(1'b1, 3'd4, 8'hFF);
        src_idle_pct = 73;
        snk_idle_pct = 36;
        for (int i = 0; i < 28; i++) send_random();

        // random phase three: no idling at all
        write_regs(1'b0, 3'd3, 8'h20);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        for (int i = 0; i < 28; i++) send_random();

        // close everything, then a second top-level value is refused
        while (in_string || nest_depth > 0)
            send_token(in_string ? CMD_STR_END : CMD_ARR_END, 0, 0, 0);
        send_token(CMD_NULL, 0, 0, 0, 1, ST_FINISHED);
        send_token(CMD_STR_START, 0, 0, 0, 1, ST_FINISHED);
        wait_drained();
        repeat (50) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("tb_json_token_serializer OK");
        end else begin
            $display("tb_json_token_serializer NOT OK");
        end
        $finish;
    end

    // Hard stop if the run hangs.
    initial begin
        #20_000_000;
        $display("tb_json_token_serializer NOT OK");
        $finish;
    end

endmodule
